>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the ellipse coverage pixel pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define EPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define EPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EPC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define EPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse coverage package
// Widths, register indexes and the geometry bundle shared by the design.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int COORD_BITS    = 12;
    localparam int COLOR_BITS    = 8;
    localparam int SQ_BITS       = 2 * COORD_BITS;
    localparam int PROD_BITS     = 4 * COORD_BITS;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = (COORD_BITS > COLOR_BITS) ? COORD_BITS : COLOR_BITS;
    localparam int IN_BITS       = 2 * COORD_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 2 * COORD_BITS + 3 * COLOR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = 2;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_CORNER_A_X,
        REG_CORNER_A_Y,
        REG_CORNER_B_X,
        REG_CORNER_B_Y,
        REG_FILLED_MODE,
        REG_CLEAR_RED,
        REG_CLEAR_GREEN,
        REG_CLEAR_BLUE
    } cfg_reg_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-1:0]        radius_t;
    typedef logic [SQ_BITS-1:0]           square_t;
    typedef logic [PROD_BITS-1:0]         prod_t;
    typedef logic [COLOR_BITS-1:0]        color_t;

    typedef struct packed {
        coord_t  cx;
        coord_t  cy;
        radius_t rx_outer;
        radius_t ry_outer;
        radius_t rx_inner;
        radius_t ry_inner;
        square_t rx2_outer;
        square_t ry2_outer;
        square_t rx2_inner;
        square_t ry2_inner;
        prod_t   rhs_outer;
        prod_t   rhs_inner;
        logic    inner_en;
        color_t  red;
        color_t  green;
        color_t  blue;
    } geom_t;

endpackage

>>> rtl/ellipse_pixel_coverage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse pixel coverage core
// Tests one pixel per item against an axis-aligned ellipse and its inward
// outline, and returns the coverage and the colour choice for that pixel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         pixel_x, pixel_y
//  m_axis    out        out_x, out_y, colour; tuser covered, paint_clear
//  cfg       in         register index and write data
//
//  One item per cycle while m_axis does not stall; each item passes through
//  the five register stages from acceptance to result.
//  Geometry follows a write: centre and radii, squares, then products.
//  Reset clears the valid bits and the registers; there is no clearing pass.
//  A stall on m_axis holds every stage that is full and fills the bubbles.
// ----------------------------------------------------------------------------
module ellipse_pixel_coverage_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // pixel_x, pixel_y
    input  logic [epc_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_x, out_y, paint_red, paint_green, paint_blue
    output logic [epc_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
    // covered, paint_clear
    output logic [epc_pkg::OUT_TUSER_BITS-1:0]    m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [epc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [epc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import epc_pkg::*;

    geom_t  geom;
    coord_t out_x, out_y;
    logic   covered, paint_clear;
    color_t paint_red, paint_green, paint_blue;

    epc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    epc_pipe u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .pixel_x     (s_axis_tdata[COORD_BITS-1:0]),
        .pixel_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .geom        (geom),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_x       (out_x),
        .out_y       (out_y),
        .covered     (covered),
        .paint_clear (paint_clear),
        .paint_red   (paint_red),
        .paint_green (paint_green),
        .paint_blue  (paint_blue)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'({paint_blue, paint_green, paint_red, out_y, out_x});
    assign m_axis_tuser = {paint_clear, covered};

endmodule

>>> rtl/epc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse coverage configuration
// Register file and the three-stage pipeline that derives centre, radii,
// squared radii and the right-hand side of both implicit tests.
// ----------------------------------------------------------------------------
module epc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [epc_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [epc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output epc_pkg::geom_t                     geom
);
    import epc_pkg::*;

    coord_t  ax_reg, ay_reg, bx_reg, by_reg;
    logic    filled_reg;
    color_t  red_reg, green_reg, blue_reg;

    coord_t  cx_reg, cy_reg;
    radius_t rxo_reg, ryo_reg, rxi_reg, ryi_reg;
    square_t rx2o_reg, ry2o_reg, rx2i_reg, ry2i_reg;
    prod_t   rhso_reg, rhsi_reg;

    logic signed [COORD_BITS:0]   sum_x, sum_y, adj_x, adj_y;
    logic signed [COORD_BITS:0]   dif_xo, dif_yo;
    logic signed [COORD_BITS+1:0] dif_xi, dif_yi;
    logic [COORD_BITS:0]          mag_xo, mag_yo;
    logic [COORD_BITS+1:0]        mag_xi, mag_yi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg     <= '0;
            ay_reg     <= '0;
            bx_reg     <= '0;
            by_reg     <= '0;
            filled_reg <= 1'b0;
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_CORNER_A_X:  ax_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CORNER_A_Y:  ay_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CORNER_B_X:  bx_reg     <= cfg_data[COORD_BITS-1:0];
                REG_CORNER_B_Y:  by_reg     <= cfg_data[COORD_BITS-1:0];
                REG_FILLED_MODE: filled_reg <= cfg_data[0];
                REG_CLEAR_RED:   red_reg    <= cfg_data[COLOR_BITS-1:0];
                REG_CLEAR_GREEN: green_reg  <= cfg_data[COLOR_BITS-1:0];
                REG_CLEAR_BLUE:  blue_reg   <= cfg_data[COLOR_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // The inward move shifts both corners oppositely, so the inner centre
    // equals the outer one. The centre truncates toward zero.
    always_comb
    begin
        sum_x  = (COORD_BITS+1)'(ax_reg) + (COORD_BITS+1)'(bx_reg);
        sum_y  = (COORD_BITS+1)'(ay_reg) + (COORD_BITS+1)'(by_reg);
        adj_x  = sum_x + {{COORD_BITS{1'b0}}, sum_x[COORD_BITS]};
        adj_y  = sum_y + {{COORD_BITS{1'b0}}, sum_y[COORD_BITS]};
        dif_xo = (COORD_BITS+1)'(bx_reg) - (COORD_BITS+1)'(ax_reg);
        dif_yo = (COORD_BITS+1)'(by_reg) - (COORD_BITS+1)'(ay_reg);
        dif_xi = (COORD_BITS+2)'(dif_xo) - (COORD_BITS+2)'(2);
        dif_yi = (COORD_BITS+2)'(dif_yo) - (COORD_BITS+2)'(2);
        mag_xo = dif_xo[COORD_BITS] ? -dif_xo : dif_xo;
        mag_yo = dif_yo[COORD_BITS] ? -dif_yo : dif_yo;
        mag_xi = dif_xi[COORD_BITS+1] ? -dif_xi : dif_xi;
        mag_yi = dif_yi[COORD_BITS+1] ? -dif_yi : dif_yi;
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= adj_x[COORD_BITS:1];
        cy_reg   <= adj_y[COORD_BITS:1];
        rxo_reg  <= mag_xo[COORD_BITS:1];
        ryo_reg  <= mag_yo[COORD_BITS:1];
        rxi_reg  <= mag_xi[COORD_BITS:1];
        ryi_reg  <= mag_yi[COORD_BITS:1];
        rx2o_reg <= SQ_BITS'(rxo_reg) * SQ_BITS'(rxo_reg);
        ry2o_reg <= SQ_BITS'(ryo_reg) * SQ_BITS'(ryo_reg);
        rx2i_reg <= SQ_BITS'(rxi_reg) * SQ_BITS'(rxi_reg);
        ry2i_reg <= SQ_BITS'(ryi_reg) * SQ_BITS'(ryi_reg);
        rhso_reg <= PROD_BITS'(rx2o_reg) * PROD_BITS'(ry2o_reg);
        rhsi_reg <= PROD_BITS'(rx2i_reg) * PROD_BITS'(ry2i_reg);
    end

    always_comb
    begin
        geom.cx        = cx_reg;
        geom.cy        = cy_reg;
        geom.rx_outer  = rxo_reg;
        geom.ry_outer  = ryo_reg;
        geom.rx_inner  = rxi_reg;
        geom.ry_inner  = ryi_reg;
        geom.rx2_outer = rx2o_reg;
        geom.ry2_outer = ry2o_reg;
        geom.rx2_inner = rx2i_reg;
        geom.ry2_inner = ry2i_reg;
        geom.rhs_outer = rhso_reg;
        geom.rhs_inner = rhsi_reg;
        geom.inner_en  = !filled_reg;
        geom.red       = red_reg;
        geom.green     = green_reg;
        geom.blue      = blue_reg;
    end

endmodule

>>> rtl/epc_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse coverage pixel pipeline
// Five register stages: input capture, offsets and box test, squares,
// cross products, then the implicit compare and the colour choice.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epc_pipe (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  epc_pkg::coord_t        pixel_x,
    input  epc_pkg::coord_t        pixel_y,
    input  epc_pkg::geom_t         geom,
    output logic                   out_valid,
    input  logic                   out_ready,
    output epc_pkg::coord_t        out_x,
    output epc_pkg::coord_t        out_y,
    output logic                   covered,
    output logic                   paint_clear,
    output epc_pkg::color_t        paint_red,
    output epc_pkg::color_t        paint_green,
    output epc_pkg::color_t        paint_blue
);
    import epc_pkg::*;

    logic    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic    adv1, adv2, adv3, adv4, adv5;

    coord_t  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    radius_t adx2_reg, ady2_reg;
    logic    boxo2_reg, boxi2_reg, boxo3_reg, boxi3_reg, boxo4_reg, boxi4_reg;
    square_t dx2_reg, dy2_reg;
    prod_t   txo_reg, tyo_reg, txi_reg, tyi_reg;

    coord_t  x5_reg, y5_reg;
    logic    cov5_reg, clr5_reg;
    color_t  red5_reg, green5_reg, blue5_reg;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        mag_x, mag_y;
    radius_t                    adx_next, ady_next;
    logic [PROD_BITS:0]         lhs_o, lhs_i;
    logic                       in_outer, in_inner;

    // A stage moves on when it is empty or the stage after it moves on.
    assign adv5     = !v5_reg || out_ready;
    assign adv4     = !v4_reg || adv5;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
        end
    end

    // A pixel lies in the box exactly when each offset magnitude is within
    // the radius on that axis.
    always_comb
    begin
        dx       = (COORD_BITS+1)'(x1_reg) - (COORD_BITS+1)'(geom.cx);
        dy       = (COORD_BITS+1)'(y1_reg) - (COORD_BITS+1)'(geom.cy);
        mag_x    = dx[COORD_BITS] ? -dx : dx;
        mag_y    = dy[COORD_BITS] ? -dy : dy;
        adx_next = mag_x[COORD_BITS-1:0];
        ady_next = mag_y[COORD_BITS-1:0];
    end

    always_comb
    begin
        lhs_o    = {1'b0, txo_reg} + {1'b0, tyo_reg};
        lhs_i    = {1'b0, txi_reg} + {1'b0, tyi_reg};
        in_outer = boxo4_reg && (lhs_o <= {1'b0, geom.rhs_outer});
        in_inner = geom.inner_en && boxi4_reg && (lhs_i <= {1'b0, geom.rhs_inner});
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            x1_reg <= pixel_x;
            y1_reg <= pixel_y;
        end
        if (adv2)
        begin
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            adx2_reg  <= adx_next;
            ady2_reg  <= ady_next;
            boxo2_reg <= (adx_next <= geom.rx_outer) && (ady_next <= geom.ry_outer);
            boxi2_reg <= (adx_next <= geom.rx_inner) && (ady_next <= geom.ry_inner);
        end
        if (adv3)
        begin
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            dx2_reg   <= SQ_BITS'(adx2_reg) * SQ_BITS'(adx2_reg);
            dy2_reg   <= SQ_BITS'(ady2_reg) * SQ_BITS'(ady2_reg);
            boxo3_reg <= boxo2_reg;
            boxi3_reg <= boxi2_reg;
        end
        if (adv4)
        begin
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
            txo_reg   <= PROD_BITS'(dx2_reg) * PROD_BITS'(geom.ry2_outer);
            tyo_reg   <= PROD_BITS'(dy2_reg) * PROD_BITS'(geom.rx2_outer);
            txi_reg   <= PROD_BITS'(dx2_reg) * PROD_BITS'(geom.ry2_inner);
            tyi_reg   <= PROD_BITS'(dy2_reg) * PROD_BITS'(geom.rx2_inner);
            boxo4_reg <= boxo3_reg;
            boxi4_reg <= boxi3_reg;
        end
        if (adv5)
        begin
            x5_reg     <= x4_reg;
            y5_reg     <= y4_reg;
            cov5_reg   <= in_outer || in_inner;
            clr5_reg   <= in_inner;
            red5_reg   <= in_inner ? geom.red : '0;
            green5_reg <= in_inner ? geom.green : '0;
            blue5_reg  <= in_inner ? geom.blue : '0;
        end
    end

    assign out_valid   = v5_reg;
    assign out_x       = x5_reg;
    assign out_y       = y5_reg;
    assign covered     = cov5_reg;
    assign paint_clear = clr5_reg;
    assign paint_red   = red5_reg;
    assign paint_green = green5_reg;
    assign paint_blue  = blue5_reg;

    `EPC_ASSERT_NOW(a_clear_is_covered, clk, rst_n, out_valid && paint_clear, covered)
    `EPC_ASSERT_NOW(a_empty_out_ready, clk, rst_n, !v5_reg, in_ready)
    `EPC_ASSERT_NEXT(a_stall_keeps_item, clk, rst_n, v3_reg && !adv4, v3_reg)

endmodule

>>> tb/ellipse_pixel_coverage_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ellipse pixel coverage core test
// Streams pixel coordinates through the core under several ellipse settings
// and checks the coordinates, coverage and paint fields of each result against a
// scoreboard that recomputes the outer and inner ellipse tests in 64 bits.
// ----------------------------------------------------------------------------
module ellipse_pixel_coverage_core_test;

    import epc_pkg::*;

    localparam logic [CFG_ADDR_BITS-1:0] FIRST_SPARE_REG = 8;
    localparam int ITEMS_PER_SETTING = 100;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   covered;
        logic   clear;
        color_t red;
        color_t green;
        color_t blue;
    } paint_t;

    class coverage_scoreboard;
        coord_t      ax, ay, bx, by;
        logic        fill;
        color_t      red, green, blue;
        paint_t      expected_paint[$];
        int unsigned fails;

        function new();
            ax = '0; ay = '0; bx = '0; by = '0;
            fill = 1'b0;
            red = '0; green = '0; blue = '0;
            fails = 0;
        endfunction

        function int pending();
            return expected_paint.size();
        endfunction

        function void set_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
            case (addr)
                REG_CORNER_A_X:  ax = coord_t'(data[COORD_BITS-1:0]);
                REG_CORNER_A_Y:  ay = coord_t'(data[COORD_BITS-1:0]);
                REG_CORNER_B_X:  bx = coord_t'(data[COORD_BITS-1:0]);
                REG_CORNER_B_Y:  by = coord_t'(data[COORD_BITS-1:0]);
                REG_FILLED_MODE: fill = data[0];
                REG_CLEAR_RED:   red = data[COLOR_BITS-1:0];
                REG_CLEAR_GREEN: green = data[COLOR_BITS-1:0];
                REG_CLEAR_BLUE:  blue = data[COLOR_BITS-1:0];
                default: ;
            endcase
        endfunction

        function bit in_ellipse(longint cax, cay, cbx, cby, px, py);
            longint cx, cy, rx, ry, dx, dy;
            cx = (cax + cbx) / 2;
            cy = (cay + cby) / 2;
            rx = ((cbx >= cax) ? cbx - cax : cax - cbx) / 2;
            ry = ((cby >= cay) ? cby - cay : cay - cby) / 2;
            if (px < cx - rx || px > cx + rx || py < cy - ry || py > cy + ry)
                return 1'b0;
            dx = px - cx;
            dy = py - cy;
            return dx * dx * ry * ry + dy * dy * rx * rx <= rx * rx * ry * ry;
        endfunction

        function void note_pixel(coord_t x, coord_t y);
            paint_t e;
            bit     outer, inner;
            outer = in_ellipse(ax, ay, bx, by, x, y);
            inner = !fill && in_ellipse(longint'(ax) + 1, longint'(ay) + 1,
                                        longint'(bx) - 1, longint'(by) - 1, x, y);
            e.x = x;
            e.y = y;
            e.covered = outer || inner;
            e.clear = inner;
            e.red = inner ? red : '0;
            e.green = inner ? green : '0;
            e.blue = inner ? blue : '0;
            expected_paint = {expected_paint, e};
        endfunction

        function void compare_field(string name, logic [COORD_BITS-1:0] want,
                                    logic [COORD_BITS-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                fails++;
            end
        endfunction

        function void check_paint(logic [OUT_TDATA_BITS-1:0] tdata,
                                  logic [OUT_TUSER_BITS-1:0] tuser);
            paint_t e;
            if (expected_paint.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, tdata, tuser);
                fails++;
                return;
            end
            e = expected_paint.pop_front();
            compare_field("out_x", e.x, tdata[COORD_BITS-1:0]);
            compare_field("out_y", e.y, tdata[2*COORD_BITS-1:COORD_BITS]);
            compare_field("paint_red", e.red, tdata[2*COORD_BITS +: COLOR_BITS]);
            compare_field("paint_green", e.green,
                          tdata[2*COORD_BITS+COLOR_BITS +: COLOR_BITS]);
            compare_field("paint_blue", e.blue, tdata[2*COORD_BITS+2*COLOR_BITS +: COLOR_BITS]);
            compare_field("covered", e.covered, tuser[0]);
            compare_field("paint_clear", e.clear, tuser[1]);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // pixel_x, pixel_y
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // out_x, out_y, paint_red, paint_green, paint_blue
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    // covered, paint_clear
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    coverage_scoreboard board;
    int unsigned        src_idle_pct;
    int unsigned        sink_idle_pct;
    logic               stall_sink;
    int                 box_ax, box_ay, box_bx, box_by;

    ellipse_pixel_coverage_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_pixel(input coord_t x, input coord_t y);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata <= {y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pixel(x, y);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_addr <= addr;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(addr, data);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input int ax, input int ay, input int bx, input int by,
                             input logic [CFG_DATA_BITS-1:0] fill,
                             input logic [CFG_DATA_BITS-1:0] r,
                             input logic [CFG_DATA_BITS-1:0] g,
                             input logic [CFG_DATA_BITS-1:0] b);
        write_reg(FIRST_SPARE_REG + CFG_ADDR_BITS'($urandom_range(7)),
                  CFG_DATA_BITS'($urandom));
        write_reg(REG_CORNER_A_X, ax[CFG_DATA_BITS-1:0]);
        write_reg(REG_CORNER_A_Y, ay[CFG_DATA_BITS-1:0]);
        write_reg(REG_CORNER_B_X, bx[CFG_DATA_BITS-1:0]);
        write_reg(REG_CORNER_B_Y, by[CFG_DATA_BITS-1:0]);
        write_reg(REG_FILLED_MODE, fill);
        write_reg(REG_CLEAR_RED, r);
        write_reg(REG_CLEAR_GREEN, g);
        write_reg(REG_CLEAR_BLUE, b);
        cfg_valid <= 1'b0;
        box_ax = ax;
        box_ay = ay;
        box_bx = bx;
        box_by = by;
    endtask

    function automatic coord_t near_span(int lo, int hi);
        return coord_t'(lo - 3 + int'($urandom_range(hi - lo + 6)));
    endfunction

    function automatic int rand_coord();
        return int'(coord_t'($urandom));
    endfunction

    initial
    begin : result_sink
        int hold_left;
        bit stall_seen;
        hold_left = 0;
        stall_seen = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_paint(m_axis_tdata, m_axis_tuser);
            if (stall_sink && !stall_seen)
            begin
                hold_left = 400;
                stall_seen = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin : stimulus
        int cx, cy, wx, wy;
        int ax, ay, bx, by;
        board = new();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        box_ax = 0;
        box_ay = 0;
        box_bx = 0;
        box_by = 0;
        rst_n <= 1'b0;
        stall_sink <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_addr <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a point ellipse at the origin in outline mode.
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        send_pixel(-2048, -2048);
        send_pixel(2047, 2047);
        drain();

        // Outline ring, inner area, and the edges of both boxes.
        configure(-10, -6, 10, 6, 12'h000, 12'hFA5, 12'h13C, 12'h0FF);
        send_pixel(0, 0);
        send_pixel(9, 0);
        send_pixel(10, 0);
        send_pixel(11, 0);
        send_pixel(0, 5);
        send_pixel(0, 6);
        send_pixel(-10, -6);
        send_pixel(7, 4);
        drain();

        // Corner a right of corner b, so the inner box is the wider one.
        configure(5, 3, -5, -3, 12'hFFE, 12'h012, 12'h034, 12'h056);
        send_pixel(6, 0);
        send_pixel(-6, 0);
        send_pixel(0, 4);
        send_pixel(0, 0);
        drain();

        // Full-range filled ellipse.
        configure(-2048, -2048, 2047, 2047, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_pixel(-2048, -2048);
        send_pixel(2047, 2047);
        send_pixel(0, 0);
        send_pixel(-2048, 0);
        send_pixel(2047, -1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 82 : 0;
            sink_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 6 : 0;
            for (int slot = 0; slot < 4; slot++)
            begin
                case (slot)
                    0:
                    begin
                        if ($urandom_range(1))
                        begin
                            ax = -2048; ay = -2048; bx = 2047; by = 2047;
                        end
                        else
                        begin
                            ax = 2047; ay = 2047; bx = -2048; by = -2048;
                        end
                    end
                    1:
                    begin
                        cx = int'($urandom_range(3000)) - 1500;
                        cy = int'($urandom_range(3000)) - 1500;
                        wx = $urandom_range(300);
                        wy = $urandom_range(300);
                        ax = cx + wx; bx = cx - wx;
                        ay = cy + wy; by = cy - wy;
                    end
                    2:
                    begin
                        cx = int'($urandom_range(4000)) - 2000;
                        cy = int'($urandom_range(4000)) - 2000;
                        ax = cx + int'($urandom_range(16)) - 8;
                        bx = cx + int'($urandom_range(16)) - 8;
                        ay = cy + int'($urandom_range(16)) - 8;
                        by = cy + int'($urandom_range(16)) - 8;
                    end
                    default:
                    begin
                        ax = rand_coord(); ay = rand_coord();
                        bx = rand_coord(); by = rand_coord();
                    end
                endcase
                configure(ax, ay, bx, by, CFG_DATA_BITS'($urandom),
                          CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom),
                          CFG_DATA_BITS'($urandom));
                if (phase == 2 && slot == 1)
                    stall_sink <= 1'b1;
                for (int n = 0; n < ITEMS_PER_SETTING; n++)
                begin
                    if ($urandom_range(99) < 70)
                        send_pixel(near_span((box_ax < box_bx) ? box_ax : box_bx,
                                             (box_ax < box_bx) ? box_bx : box_ax),
                                   near_span((box_ay < box_by) ? box_ay : box_by,
                                             (box_ay < box_by) ? box_by : box_ay));
                    else
                        send_pixel(coord_t'($urandom), coord_t'($urandom));
                end
                drain();
            end
        end

        repeat (20) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
